### rtl/core/kslp_pkg.sv
`default_nettype none
package kslp_pkg;

	// Per-key machine state.
	typedef enum logic [1:0] {
		MODE_WAIT    = 2'd0,
		MODE_COUNT   = 2'd1,
		MODE_RELEASE = 2'd2
	} mode_t;

	// Press flag held for each key until cleared.
	typedef enum logic [1:0] {
		FLAG_NONE  = 2'd0,
		FLAG_SHORT = 2'd1,
		FLAG_LONG  = 2'd2
	} flag_t;

	localparam int THR_W       = 8;
	localparam int COUNT_W     = 8;
	localparam int PIN_W       = 4;
	localparam int QUERY_W     = 2;
	localparam int MASK_W      = 4;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 16;
	localparam int CFG_IDX_W   = 1;

	localparam logic [THR_W-1:0] LONG_THR_RESET  = 8'd100;
	localparam logic [THR_W-1:0] SHORT_THR_RESET = 8'd8;

	// Register indexes on the configuration channel.
	localparam logic [CFG_IDX_W-1:0] REG_LONG_THR  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_THR = 1'b1;

	// Thresholds seen by every lane.
	typedef struct packed {
		logic [THR_W-1:0] long_thr;
		logic [THR_W-1:0] short_thr;
	} thr_t;

	// What an accepted transaction asks of the lanes.
	typedef struct packed {
		logic step;
		logic clear;
	} cmd_t;

	// One result item.
	typedef struct packed {
		logic              queried_short;
		logic [MASK_W-1:0] long_mask;
		logic [MASK_W-1:0] short_mask;
	} result_t;

endpackage
`default_nettype wire

### rtl/core/key_short_long_press_detector_top.sv
`default_nettype none
// Short and long key press detector for NUM_KEYS keys. Each input transaction
// is either a scan tick (s_tuser low) carrying the active-low pin levels of
// keys 0 to 3, or a clear command (s_tuser high) that drops every press flag
// without advancing the key machines. Keys at index 4 and above have no pin
// and always read as released. Each key counts the ticks it is held; once the
// count exceeds long_threshold its flag becomes long, and a release after more
// than short_threshold ticks sets it to short. Flags stay until cleared. Every
// input transaction yields exactly one result transaction holding the short
// and long masks and the short status of the key named by query_key (zero if
// that key does not exist). While the skid register is free, the block takes
// one item per clock cycle: all key machines update in parallel and the result
// is registered into the output register, or the skid register if the output
// stalls. A two-entry output stage (output register plus skid register) lets
// an item be accepted while the previous result still waits. Thresholds reset
// to 100 and 8 and should only be written while the block is idle.
module key_short_long_press_detector_top #(
	parameter int NUM_KEYS = 4
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Input stream.
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	// tdata: pin_levels [3:0], query_key [5:4], zero [7:6].
	input  wire logic [kslp_pkg::IN_TDATA_W-1:0]     s_tdata,
	// tuser: operation (0 scan tick, 1 clear all flags).
	input  wire logic                                s_tuser,
	// Result stream.
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	// tdata: short_mask [3:0], long_mask [7:4], queried_short [8], zero [15:9].
	output logic [kslp_pkg::OUT_TDATA_W-1:0]         m_tdata,
	// Configuration writes: index 0 long_threshold, index 1 short_threshold.
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [kslp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [kslp_pkg::THR_W-1:0]          cfg_data
);
	import kslp_pkg::*;

	thr_t               thr_q;
	cmd_t               cmd;
	logic               in_acc;
	logic               out_take;
	logic [PIN_W-1:0]   pin_levels;
	logic [QUERY_W-1:0] query_key;
	flag_t              flags [NUM_KEYS];
	result_t            result;

	result_t            out_q;
	logic               out_valid_q;
	result_t            skid_q;
	logic               skid_valid_q;

	// The configuration channel never stalls.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.long_thr  <= LONG_THR_RESET;
			thr_q.short_thr <= SHORT_THR_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LONG_THR:  thr_q.long_thr  <= cfg_data;
				REG_SHORT_THR: thr_q.short_thr <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Input is taken whenever the skid register is free, so at most one
	// result can be waiting behind the output register.
	assign s_tready   = !skid_valid_q;
	assign in_acc     = s_tvalid && s_tready;
	assign out_take   = m_tvalid && m_tready;
	assign pin_levels = s_tdata[PIN_W-1:0];
	assign query_key  = s_tdata[PIN_W +: QUERY_W];

	assign cmd.step  = in_acc;
	assign cmd.clear = s_tuser;

	// One lane per key; keys without a pin see a released level.
	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		logic down;
		if (k < PIN_W) begin : g_pin
			assign down = !pin_levels[k];
		end else begin : g_nopin
			assign down = 1'b0;
		end
		kslp_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.thr    (thr_q),
			.down   (down),
			.flag_d (flags[k])
		);
	end

	kslp_merge #(
		.NUM_KEYS (NUM_KEYS)
	) u_merge (
		.flags     (flags),
		.query_key (query_key),
		.result    (result)
	);

	// Output register with a skid register behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_acc;
			end
		end else if (in_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_acc) begin
				out_q <= result;
			end
		end else if (in_acc) begin
			skid_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'(out_q);

endmodule
`default_nettype wire

### rtl/core/kslp_lane.sv
`default_nettype none
// One key's press machine. flag_d is the flag as it stands after the
// current input item, so the merge stage can form the result in the same cycle.
module kslp_lane (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire kslp_pkg::cmd_t cmd,
	input  wire kslp_pkg::thr_t thr,
	input  wire logic           down,
	output kslp_pkg::flag_t     flag_d
);
	import kslp_pkg::*;

	mode_t               mode_q, mode_d;
	logic [COUNT_W-1:0]  count_q, count_d, count_inc;
	logic                once_q, once_d;
	flag_t               flag_q;

	assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;

	always_comb begin
		mode_d  = mode_q;
		count_d = count_q;
		once_d  = once_q;
		flag_d  = flag_q;
		if (cmd.clear) begin
			flag_d = FLAG_NONE;
		end else begin
			case (mode_q)
				MODE_WAIT: begin
					if (down) begin
						mode_d  = MODE_COUNT;
						once_d  = 1'b0;
						count_d = '0;
					end
				end
				MODE_COUNT: begin
					if (down) begin
						count_d = count_inc;
						if (count_inc > thr.long_thr) begin
							flag_d = FLAG_LONG;
							once_d = 1'b0;
							mode_d = MODE_RELEASE;
						end else begin
							once_d = 1'b1;
						end
					end else if (once_q && (count_q > thr.short_thr)) begin
						flag_d = FLAG_SHORT;
						mode_d = MODE_RELEASE;
					end else begin
						mode_d = MODE_WAIT;
					end
				end
				MODE_RELEASE: begin
					if (!down) begin
						mode_d = MODE_WAIT;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_WAIT;
			count_q <= '0;
			once_q  <= 1'b0;
			flag_q  <= FLAG_NONE;
		end else if (cmd.step) begin
			mode_q  <= mode_d;
			count_q <= count_d;
			once_q  <= once_d;
			flag_q  <= flag_d;
		end
	end

endmodule
`default_nettype wire

### rtl/core/kslp_merge.sv
`default_nettype none
// Gathers the lanes' flags into the two masks and the queried key's status.
module kslp_merge #(
	parameter int NUM_KEYS = 4
) (
	input  wire kslp_pkg::flag_t                 flags [NUM_KEYS],
	input  wire logic [kslp_pkg::QUERY_W-1:0]    query_key,
	output kslp_pkg::result_t                    result
);
	import kslp_pkg::*;

	// Only the first keys fit the masks; the query field cannot reach beyond them.
	localparam int MASK_KEYS = (NUM_KEYS < MASK_W) ? NUM_KEYS : MASK_W;

	always_comb begin
		result = '0;
		for (int k = 0; k < MASK_KEYS; k++) begin
			result.short_mask[k] = (flags[k] == FLAG_SHORT);
			result.long_mask[k]  = (flags[k] == FLAG_LONG);
			if ((query_key == QUERY_W'(k)) && (flags[k] == FLAG_SHORT)) begin
				result.queried_short = 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the short and long key press detector. Every input
// transaction is mirrored by a behavioural model of the four key machines, and
// each result transaction is compared field by field with the oldest
// prediction still waiting in the queue.
module testbench;
	import kslp_pkg::*;

	localparam int NUM_KEYS     = 4;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int STALL_CYCLES = 240;
	localparam int NUM_PHASES   = 8;
	// A phase marked like this draws both thresholds at random.
	localparam int RANDOM_THR   = -1;

	// Operation carried in s_tuser.
	localparam logic OP_SCAN  = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// How the two sides of the stream pace themselves during a phase.
	typedef enum int {
		PACE_SLOW_SINK,
		PACE_SLOW_SOURCE,
		PACE_FULL
	} pace_t;

	// One row of the directed table. The expected result is only used when
	// the row is marked as having one typed in; otherwise the model decides.
	typedef struct packed {
		logic         op;
		logic [3:0]   pins;
		logic [1:0]   query;
		logic [7:0]   reps;
		logic         typed;
		result_t      want;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic                   s_tuser   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [THR_W-1:0]       cfg_data  = '0;

	// Behavioural copy of the block: thresholds and per-key machine state.
	logic [THR_W-1:0]   thr_long  = LONG_THR_RESET;
	logic [THR_W-1:0]   thr_short = SHORT_THR_RESET;
	mode_t              model_mode [NUM_KEYS];
	logic [COUNT_W-1:0] hold_ticks [NUM_KEYS];
	logic               held_once  [NUM_KEYS];
	flag_t              model_flag [NUM_KEYS];

	// Predicted results, oldest first.
	result_t pending_results [$];

	// Per-key press and release segments for the random part.
	int  seg_left [NUM_KEYS];
	bit  seg_down [NUM_KEYS];

	int  errors          = 0;
	int  items_sent      = 0;
	int  results_checked = 0;
	int  cycle_count     = 0;
	int  send_idle_pct   = 0;
	int  recv_idle_pct   = 0;
	int  stall_asked     = 0;
	int  stall_served    = 0;
	int  stall_left      = 0;

	// Directed table, run with the thresholds still at their reset values
	// of 100 and 8.
	dir_row_t directed_rows [0:10] = '{
		// Everything released straight after reset: no flag anywhere.
		{OP_SCAN,  4'hF, 2'd0, 8'd1, 1'b1, 9'd0},
		// A clear with all pins low must not start any key counting.
		{OP_CLEAR, 4'h0, 2'd3, 8'd1, 1'b1, 9'd0},
		// All keys pressed: the machines enter counting, no flag yet.
		{OP_SCAN,  4'h0, 2'd3, 8'd1, 1'b1, 9'd0},
		// Hold long enough to pass the short threshold.
		{OP_SCAN,  4'h0, 2'd1, 8'd9, 1'b0, 9'd0},
		// A clear in the middle of a hold leaves the counts alone.
		{OP_CLEAR, 4'h0, 2'd2, 8'd1, 1'b1, 9'd0},
		// Keys 2 and 3 let go: short press on both.
		{OP_SCAN,  4'hC, 2'd0, 8'd1, 1'b0, 9'd0},
		{OP_SCAN,  4'hC, 2'd2, 8'd1, 1'b0, 9'd0},
		{OP_CLEAR, 4'hC, 2'd1, 8'd1, 1'b1, 9'd0},
		// Key 1 lets go as well while key 0 is still held.
		{OP_SCAN,  4'hE, 2'd3, 8'd2, 1'b0, 9'd0},
		// Key 0 lets go last, also past the short threshold.
		{OP_SCAN,  4'hF, 2'd0, 8'd1, 1'b0, 9'd0},
		{OP_SCAN,  4'hF, 2'd3, 8'd1, 1'b0, 9'd0}
	};

	// Random phases. The first keeps the reset thresholds; the others write
	// both registers, including the extremes of the 8-bit range.
	int    phase_long  [NUM_PHASES] = '{100, 4, 0, 10, 255, 254, 6, RANDOM_THR};
	int    phase_short [NUM_PHASES] = '{8, 1, 0, 3, 254, 0, 9, RANDOM_THR};
	int    phase_items [NUM_PHASES] = '{350, 220, 160, 240, 300, 280, 180, 200};
	pace_t phase_pace  [NUM_PHASES] = '{PACE_SLOW_SINK, PACE_SLOW_SINK, PACE_SLOW_SINK,
		PACE_SLOW_SOURCE, PACE_SLOW_SOURCE, PACE_FULL, PACE_FULL, PACE_FULL};

	key_short_long_press_detector_top #(
		.NUM_KEYS(NUM_KEYS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog: a run that hangs on a handshake ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("Mismatch at %0t: %s is %0h, expected %0h", $time, what, got, want);
		errors++;
	endtask

	// Advances every key machine by one transaction and returns the result
	// that the block should produce for it.
	function automatic result_t advance_keys(input logic op, input logic [3:0] pins,
			input logic [1:0] query);
		result_t res;
		int      k;
		logic    down;
		res = '0;
		for (k = 0; k < NUM_KEYS; k++) begin
			if (op == OP_CLEAR) begin
				model_flag[k] = FLAG_NONE;
			end else begin
				// Keys beyond the pin field have no pin and read as released.
				down = (k < PIN_W) ? !pins[k] : 1'b0;
				case (model_mode[k])
					MODE_WAIT: begin
						if (down) begin
							model_mode[k] = MODE_COUNT;
							held_once[k]  = 1'b0;
							hold_ticks[k] = '0;
						end
					end
					MODE_COUNT: begin
						if (down) begin
							held_once[k] = 1'b1;
							// The count saturates rather than wrapping.
							if (hold_ticks[k] != {COUNT_W{1'b1}})
								hold_ticks[k] = hold_ticks[k] + 1'b1;
							if (hold_ticks[k] > thr_long) begin
								model_flag[k] = FLAG_LONG;
								held_once[k]  = 1'b0;
								model_mode[k] = MODE_RELEASE;
							end
						end else if (held_once[k] && hold_ticks[k] > thr_short) begin
							model_flag[k] = FLAG_SHORT;
							model_mode[k] = MODE_RELEASE;
						end else begin
							model_mode[k] = MODE_WAIT;
						end
					end
					MODE_RELEASE: begin
						if (!down)
							model_mode[k] = MODE_WAIT;
					end
					default: begin
					end
				endcase
			end
		end
		for (k = 0; k < NUM_KEYS && k < MASK_W; k++) begin
			res.short_mask[k] = (model_flag[k] == FLAG_SHORT);
			res.long_mask[k]  = (model_flag[k] == FLAG_LONG);
		end
		if (int'(query) < NUM_KEYS && model_flag[query] == FLAG_SHORT)
			res.queried_short = 1'b1;
		return res;
	endfunction

	// Offers one input transaction, waits for it to be taken and records the
	// prediction. s_tvalid is only lowered during a gap, so back-to-back
	// items never see it dropped and raised in the same step.
	task automatic send_item(input logic op, input logic [3:0] pins, input logic [1:0] query,
			input logic typed, input result_t want);
		result_t pred;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {2'b00, query, pins};
		do @(posedge clk); while (!s_tready);
		pred = advance_keys(op, pins, query);
		pending_results.push_back(typed ? want : pred);
		items_sent++;
	endtask

	// Lets every outstanding result come back and then waits out the drain period,
	// so that the block is idle before the thresholds change.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes both threshold registers as two back-to-back transactions.
	task automatic write_thresholds(input logic [THR_W-1:0] long_val,
			input logic [THR_W-1:0] short_val);
		cfg_valid <= 1'b1;
		cfg_index <= REG_LONG_THR;
		cfg_data  <= long_val;
		do @(posedge clk); while (!cfg_ready);
		thr_long = long_val;
		cfg_index <= REG_SHORT_THR;
		cfg_data  <= short_val;
		do @(posedge clk); while (!cfg_ready);
		thr_short = short_val;
		cfg_valid <= 1'b0;
	endtask

	function automatic void set_pace(input pace_t pace);
		case (pace)
			PACE_SLOW_SINK: begin
				send_idle_pct = 34;
				recv_idle_pct = 86;
			end
			PACE_SLOW_SOURCE: begin
				send_idle_pct = 86;
				recv_idle_pct = 34;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endfunction

	// Hold lengths cluster around both thresholds so that releases land just
	// either side of them; the rest are spread over the whole useful range.
	function automatic int pick_hold_len();
		int base;
		int len;
		case ($urandom_range(0, 3))
			0: base = int'(thr_short);
			1: base = int'(thr_long);
			default: base = $urandom_range(0, int'(thr_long) + 3);
		endcase
		len = base + $urandom_range(0, 3);
		return (len < 1) ? 1 : len;
	endfunction

	// Pin levels for the next scan tick: each key runs through press and
	// release segments of its own, with an occasional glitch on top.
	function automatic logic [3:0] next_pins();
		logic [3:0] pins;
		int         k;
		pins = '1;
		for (k = 0; k < PIN_W; k++) begin
			if (seg_left[k] == 0) begin
				seg_down[k] = !seg_down[k];
				seg_left[k] = seg_down[k] ? pick_hold_len() : $urandom_range(1, 3);
			end
			pins[k] = !seg_down[k];
			seg_left[k]--;
		end
		if ($urandom_range(0, 99) < 5)
			pins = pins ^ (4'b0001 << $urandom_range(0, 3));
		return pins;
	endfunction

	// Result side: paces m_tready and, when asked, holds off for a long
	// stretch so that the output stage fills and the input side stalls.
	always @(posedge clk) begin
		if (stall_asked != stall_served) begin
			stall_served = stall_served + 1;
			stall_left   = STALL_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Each result transaction is checked against the oldest prediction.
	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[8:0];
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", int'(m_tdata), 0);
			end else begin
				want = pending_results.pop_front();
				if (got.short_mask !== want.short_mask)
					report_mismatch("short_mask", int'(got.short_mask),
						int'(want.short_mask));
				if (got.long_mask !== want.long_mask)
					report_mismatch("long_mask", int'(got.long_mask),
						int'(want.long_mask));
				if (got.queried_short !== want.queried_short)
					report_mismatch("queried_short", int'(got.queried_short),
						int'(want.queried_short));
				if (m_tdata[OUT_TDATA_W-1:9] !== '0)
					report_mismatch("tdata padding", int'(m_tdata[OUT_TDATA_W-1:9]), 0);
			end
			results_checked++;
		end
	end

	initial begin : stimulus
		int         k;
		int         r;
		int         p;
		int         n;
		int         long_val;
		int         short_val;
		logic       op;
		logic [3:0] pins;
		for (k = 0; k < NUM_KEYS; k++) begin
			model_mode[k] = MODE_WAIT;
			hold_ticks[k] = '0;
			held_once[k]  = 1'b0;
			model_flag[k] = FLAG_NONE;
			seg_left[k]   = 0;
			seg_down[k]   = 1'b1;
		end
		set_pace(PACE_SLOW_SINK);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, thresholds at their reset values.
		for (r = 0; r <= 10; r++) begin
			for (n = 0; n < int'(directed_rows[r].reps); n++)
				send_item(directed_rows[r].op, directed_rows[r].pins, directed_rows[r].query,
					directed_rows[r].typed, directed_rows[r].want);
		end

		// Random phases, each with its own thresholds and pacing.
		for (p = 0; p < NUM_PHASES; p++) begin
			drain();
			long_val  = phase_long[p];
			short_val = phase_short[p];
			if (long_val == RANDOM_THR) begin
				long_val  = $urandom_range(0, 15);
				short_val = $urandom_range(0, 15);
			end
			// The first phase keeps the reset thresholds.
			if (p > 0)
				write_thresholds(long_val[THR_W-1:0], short_val[THR_W-1:0]);
			set_pace(phase_pace[p]);
			// Stall the result side while the source runs flat out.
			if (phase_pace[p] == PACE_FULL && p == 5)
				stall_asked = stall_asked + 1;
			for (n = 0; n < phase_items[p]; n++) begin
				if ($urandom_range(0, 99) < 4) begin
					op   = OP_CLEAR;
					pins = 4'($urandom_range(0, 15));
				end else begin
					op   = OP_SCAN;
					pins = next_pins();
				end
				send_item(op, pins, 2'($urandom_range(0, 3)), 1'b0, '0);
			end
		end

		drain();
		if (pending_results.size() != 0)
			report_mismatch("results never delivered", pending_results.size(), 0);

		$display("Sent %0d items and checked %0d results over %0d threshold settings,",
			items_sent, results_checked, NUM_PHASES);
		$display("with both sides idling, a long output stall and thresholds from 0 to 255.");
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/core/kslp_pkg.sv
rtl/core/kslp_lane.sv
rtl/core/kslp_merge.sv
rtl/core/key_short_long_press_detector_top.sv
sim/testbench.sv
